>>> rtl/bounded_deque_with_positional_remove_assert.svh
// Assertion macros shared by the deque RTL.
// Clocked on clk_i and disabled while rst_ni is low.
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_REMOVE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BDQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BDQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDQ_ASSERT_IMP(name, ante, cons, msg)
`define BDQ_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

>>> rtl/bdq_pkg.sv
`timescale 1ns / 1ps
package bdq_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned AmountW = 16;
  localparam int unsigned EntryW  = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_BACK     = 3'd0,
    ACT_PUSH_FRONT    = 3'd1,
    ACT_POP_FRONT     = 3'd2,
    ACT_POP_BACK      = 3'd3,
    ACT_REMOVE_AT     = 3'd4,
    ACT_REMOVE_LAST_N = 3'd5,
    ACT_APPEND_SIZE   = 3'd6,
    ACT_APPEND_RANGE  = 3'd7
  } act_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_EXEC,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_SHIFT_END,
    OP_FILL,
    OP_RD_FRONT,
    OP_RD_BACK,
    OP_LOAD_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FILL,
    ST_RD_FRONT,
    ST_RD_BACK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    act_e act;
    logic pos_ok;
    logic shift_more;
    logic fill_more;
    logic refused;
    logic full;
  } dp_status_t;

endpackage

>>> rtl/bdq_dpath.sv
`timescale 1ns / 1ps
module bdq_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bdq_pkg::dp_op_e                   cmd_i,
  output bdq_pkg::dp_status_t               status_o,
  input  logic [bdq_pkg::ActionW-1:0]       action_i,
  input  logic signed [bdq_pkg::ValueW-1:0] item_value_i,
  input  logic [bdq_pkg::AmountW-1:0]       amount_i,
  output logic [bdq_pkg::EntryW-1:0]        entry_count_o,
  output logic                              is_empty_o,
  output logic signed [bdq_pkg::ValueW-1:0] front_value_o,
  output logic signed [bdq_pkg::ValueW-1:0] back_value_o,
  output logic                              overflowed_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = bdq_pkg::ValueW;
  localparam int unsigned NW = bdq_pkg::AmountW;
  localparam int unsigned EW = bdq_pkg::EntryW;
  localparam logic [CW-1:0] CapC    = CW'(CAPACITY);
  localparam logic [CW:0]   CapWide = (CW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  logic [VW-1:0] store_q [CAPACITY];
  logic [VW-1:0] rd_data_q;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] fill_n_q, fill_n_d;
  logic          refused_q, refused_d;
  bdq_pkg::act_e action_q, action_d;
  logic [VW-1:0] value_q, value_d;
  logic [NW-1:0] amount_q, amount_d;
  logic [VW-1:0] front_q, front_d;

  logic [EW-1:0] out_count_q, out_count_d;
  logic          out_empty_q, out_empty_d;
  logic [VW-1:0] out_front_q, out_front_d;
  logic [VW-1:0] out_back_q, out_back_d;
  logic          out_ovf_q, out_ovf_d;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [VW-1:0] wr_data;

  logic [CW-1:0]    idx_p1, count_p1, count_m1, free_cnt;
  logic [NW+CW-1:0] count_wide, free_wide;
  logic [NW-1:0]    count_amt, free_amt;
  logic [VW+CW-1:0] count_p1_wide, idx_p1_wide;
  logic [EW+CW-1:0] count_ent_wide;
  logic [AW-1:0]    head_p1, head_m1;
  logic             full, empty;

  // Ring position of the entry at the given offset from the head.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(off);
    if (sum >= CapWide) begin
      sum = sum - CapWide;
    end
    return sum[AW-1:0];
  endfunction

  assign idx_p1         = idx_q + CW'(1);
  assign count_p1       = count_q + CW'(1);
  assign count_m1       = (count_q == '0) ? '0 : count_q - CW'(1);
  assign free_cnt       = CapC - count_q;
  assign count_wide     = {{NW{1'b0}}, count_q};
  assign count_amt      = count_wide[NW-1:0];
  assign free_wide      = {{NW{1'b0}}, free_cnt};
  assign free_amt       = free_wide[NW-1:0];
  assign count_p1_wide  = {{VW{1'b0}}, count_p1};
  assign idx_p1_wide    = {{VW{1'b0}}, idx_p1};
  assign count_ent_wide = {{EW{1'b0}}, count_q};
  assign head_p1        = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign head_m1        = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign full           = (count_q == CapC);
  assign empty          = (count_q == '0);

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    fill_n_d    = fill_n_q;
    refused_d   = refused_q;
    action_d    = action_q;
    value_d     = value_q;
    amount_d    = amount_q;
    front_d     = front_q;
    out_count_d = out_count_q;
    out_empty_d = out_empty_q;
    out_front_d = out_front_q;
    out_back_d  = out_back_q;
    out_ovf_d   = out_ovf_q;
    wr_en       = 1'b0;
    wr_addr     = slot(head_q, count_q);
    wr_data     = value_q;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    unique case (cmd_i)
      bdq_pkg::OP_NONE: begin
      end
      bdq_pkg::OP_CAPTURE: begin
        action_d = bdq_pkg::act_e'(action_i);
        value_d  = item_value_i;
        amount_d = amount_i;
      end
      bdq_pkg::OP_EXEC: begin
        refused_d = 1'b0;
        unique case (action_q)
          bdq_pkg::ACT_PUSH_BACK: begin
            if (full) begin
              refused_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              count_d = count_p1;
            end
          end
          bdq_pkg::ACT_PUSH_FRONT: begin
            if (full) begin
              refused_d = 1'b1;
            end else begin
              head_d  = head_m1;
              wr_addr = head_m1;
              wr_en   = 1'b1;
              count_d = count_p1;
            end
          end
          bdq_pkg::ACT_POP_FRONT: begin
            if (!empty) begin
              head_d  = head_p1;
              count_d = count_m1;
            end
          end
          bdq_pkg::ACT_POP_BACK: begin
            count_d = count_m1;
          end
          bdq_pkg::ACT_REMOVE_AT: begin
            idx_d = amount_q[CW-1:0] - CW'(1);
          end
          bdq_pkg::ACT_REMOVE_LAST_N: begin
            count_d = (amount_q >= count_amt) ? '0 : count_q - amount_q[CW-1:0];
          end
          bdq_pkg::ACT_APPEND_SIZE: begin
            if (full) begin
              refused_d = 1'b1;
            end else begin
              wr_data = count_p1_wide[VW-1:0];
              wr_en   = 1'b1;
              count_d = count_p1;
            end
          end
          bdq_pkg::ACT_APPEND_RANGE: begin
            idx_d = '0;
            if (amount_q > free_amt) begin
              fill_n_d  = free_cnt;
              refused_d = 1'b1;
            end else begin
              fill_n_d = amount_q[CW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      bdq_pkg::OP_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = slot(head_q, idx_p1);
      end
      bdq_pkg::OP_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = slot(head_q, idx_q);
        wr_data = rd_data_q;
        idx_d   = idx_p1;
      end
      bdq_pkg::OP_SHIFT_END: begin
        count_d = count_m1;
      end
      bdq_pkg::OP_FILL: begin
        wr_en   = 1'b1;
        wr_data = idx_p1_wide[VW-1:0];
        count_d = count_p1;
        idx_d   = idx_p1;
      end
      bdq_pkg::OP_RD_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
      end
      bdq_pkg::OP_RD_BACK: begin
        rd_en   = 1'b1;
        rd_addr = slot(head_q, count_m1);
        front_d = rd_data_q;
      end
      bdq_pkg::OP_LOAD_OUT: begin
        out_count_d = count_ent_wide[EW-1:0];
        out_empty_d = empty;
        out_front_d = empty ? '0 : front_q;
        out_back_d  = empty ? '0 : rd_data_q;
        out_ovf_d   = refused_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    fill_n_q    <= fill_n_d;
    refused_q   <= refused_d;
    action_q    <= action_d;
    value_q     <= value_d;
    amount_q    <= amount_d;
    front_q     <= front_d;
    out_count_q <= out_count_d;
    out_empty_q <= out_empty_d;
    out_front_q <= out_front_d;
    out_back_q  <= out_back_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  assign status_o.act        = action_q;
  assign status_o.pos_ok     = (amount_q != '0) && (amount_q <= count_amt);
  assign status_o.shift_more = (idx_p1 < count_q);
  assign status_o.fill_more  = (idx_q < fill_n_q);
  assign status_o.refused    = refused_q;
  assign status_o.full       = full;

  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign front_value_o = out_front_q;
  assign back_value_o  = out_back_q;
  assign overflowed_o  = out_ovf_q;

endmodule

>>> rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
module bdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  bdq_pkg::dp_status_t status_i,
  output bdq_pkg::dp_op_e     cmd_o
);

  bdq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            load_ok;

  // The result register may be refilled when empty or drained this cycle.
  assign load_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bdq_pkg::ST_EXEC;
        end
      end
      bdq_pkg::ST_EXEC: begin
        if (status_i.act == bdq_pkg::ACT_REMOVE_AT && status_i.pos_ok) begin
          state_d = bdq_pkg::ST_SHIFT_RD;
        end else if (status_i.act == bdq_pkg::ACT_APPEND_RANGE) begin
          state_d = bdq_pkg::ST_FILL;
        end else begin
          state_d = bdq_pkg::ST_RD_FRONT;
        end
      end
      bdq_pkg::ST_SHIFT_RD: begin
        state_d = status_i.shift_more ? bdq_pkg::ST_SHIFT_WR : bdq_pkg::ST_RD_FRONT;
      end
      bdq_pkg::ST_SHIFT_WR: begin
        state_d = bdq_pkg::ST_SHIFT_RD;
      end
      bdq_pkg::ST_FILL: begin
        if (!status_i.fill_more) begin
          state_d = bdq_pkg::ST_RD_FRONT;
        end
      end
      bdq_pkg::ST_RD_FRONT: begin
        state_d = bdq_pkg::ST_RD_BACK;
      end
      bdq_pkg::ST_RD_BACK: begin
        state_d = bdq_pkg::ST_FINISH;
      end
      bdq_pkg::ST_FINISH: begin
        if (load_ok) begin
          state_d = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = bdq_pkg::OP_NONE;
    unique case (state_q)
      bdq_pkg::ST_IDLE: begin
        cmd_o = in_valid_i ? bdq_pkg::OP_CAPTURE : bdq_pkg::OP_NONE;
      end
      bdq_pkg::ST_EXEC: begin
        cmd_o = bdq_pkg::OP_EXEC;
      end
      bdq_pkg::ST_SHIFT_RD: begin
        cmd_o = status_i.shift_more ? bdq_pkg::OP_SHIFT_RD : bdq_pkg::OP_SHIFT_END;
      end
      bdq_pkg::ST_SHIFT_WR: begin
        cmd_o = bdq_pkg::OP_SHIFT_WR;
      end
      bdq_pkg::ST_FILL: begin
        cmd_o = status_i.fill_more ? bdq_pkg::OP_FILL : bdq_pkg::OP_NONE;
      end
      bdq_pkg::ST_RD_FRONT: begin
        cmd_o = bdq_pkg::OP_RD_FRONT;
      end
      bdq_pkg::ST_RD_BACK: begin
        cmd_o = bdq_pkg::OP_RD_BACK;
      end
      bdq_pkg::ST_FINISH: begin
        cmd_o = load_ok ? bdq_pkg::OP_LOAD_OUT : bdq_pkg::OP_NONE;
      end
      default: begin
        cmd_o = bdq_pkg::OP_NONE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o == bdq_pkg::OP_LOAD_OUT) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != bdq_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/bounded_deque_with_positional_remove.sv
`timescale 1ns / 1ps
`include "bounded_deque_with_positional_remove_assert.svh"
// Bounded double-ended queue of signed 32-bit values held in a ring memory.
// The input channel (in_valid_i / in_stall_o) carries one action per transfer,
// with its value and amount; the output channel (out_valid_o / out_stall_i)
// returns exactly one result per action, describing the deque afterwards.
// A transfer happens on a rising edge where valid is high and stall is low.
// Every action runs through the value memory, one access at a time. A plain
// push, pop, remove-last-N or append-size steps through execute, read front,
// read back and finish; finish loads the output register when it may be
// refilled, then returns to idle for the next input. A positional remove
// adds one read and one write per entry moved toward the head, then an end
// step; an append of a range adds one write per value, then an end step.
// The result sits in an output register, so while the receiver stalls the
// block still takes the next input; it then holds that result until the
// register drains. Reset empties the deque and drops any pending result; the
// memory contents are not cleared; an empty deque reports zero at both ends.
module bounded_deque_with_positional_remove #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bdq_pkg::ActionW-1:0]       action_i,
  input  logic signed [bdq_pkg::ValueW-1:0] item_value_i,
  input  logic [bdq_pkg::AmountW-1:0]       amount_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bdq_pkg::EntryW-1:0]        entry_count_o,
  output logic                              is_empty_o,
  output logic signed [bdq_pkg::ValueW-1:0] front_value_o,
  output logic signed [bdq_pkg::ValueW-1:0] back_value_o,
  output logic                              overflowed_o
);

  // Command from the controller and status back from the datapath.
  bdq_pkg::dp_op_e     dp_cmd;
  bdq_pkg::dp_status_t dp_status;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  bdq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .action_i      (action_i),
    .item_value_i  (item_value_i),
    .amount_i      (amount_i),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .overflowed_o  (overflowed_o)
  );

  // Once an action is taken, the block is busy on the following cycle.
  `BDQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no busy after accept")
  // An empty deque reports zero for both ends.
  `BDQ_ASSERT_IMP(a_empty_zero, out_valid_o && is_empty_o, front_value_o == '0 && back_value_o == '0, "empty result not zero")
  // A refused push or append can only be reported with the deque full.
  `BDQ_ASSERT_IMP(a_refused_full, dp_cmd == bdq_pkg::OP_LOAD_OUT && dp_status.refused, dp_status.full, "overflow without full deque")

endmodule
